### rtl/core/segment_segment_intersection_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment intersection block
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_SEGMENT_INTERSECTION_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SSI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// expression never true
`define SSI_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        !(expr)) else $error(msg);

`endif

### rtl/core/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared constants and width helpers for the segment intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssi_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // quotient bits needed to tell a clamped result from a normal one
    function automatic int ssi_quo_w(input int coord_w);
        return coord_w + 2;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ssi_divider.sv
// ----------------------------------------------------------------------------
// ssi_divider
// Pipelined restoring divider: two numerators over one shared denominator,
// one quotient bit per stage, with an overflow flag per numerator and a sideband word.
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_divider
    import ssi_pkg::*;
#(
    parameter int NUM_W  = 53,
    parameter int DEN_W  = 36,
    parameter int QUO_W  = ssi_quo_w(COORD_WIDTH_DEF),
    parameter int SIDE_W = 36
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num_x,
    input  wire logic [NUM_W-1:0]  i_num_y,
    input  wire logic [DEN_W-1:0]  i_den,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [QUO_W-1:0]       o_quo_x,
    output logic [QUO_W-1:0]       o_quo_y,
    output logic                   o_ovf_x,
    output logic                   o_ovf_y,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic              r_valid [0:QUO_W];
    logic [REM_W-1:0]  r_rem_x [0:QUO_W-1];
    logic [REM_W-1:0]  r_rem_y [0:QUO_W-1];
    logic [DEN_W-1:0]  r_den   [0:QUO_W-1];
    logic [QUO_W-1:0]  r_q_x   [0:QUO_W];
    logic [QUO_W-1:0]  r_q_y   [0:QUO_W];
    logic              r_ovf_x [0:QUO_W];
    logic              r_ovf_y [0:QUO_W];
    logic [SIDE_W-1:0] r_side  [0:QUO_W];

    logic [REM_W-1:0] w_den_top;
    assign w_den_top = REM_W'(i_den) << QUO_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
        r_rem_x[0] <= REM_W'(i_num_x);
        r_rem_y[0] <= REM_W'(i_num_y);
        r_den[0]   <= i_den;
        r_q_x[0]   <= '0;
        r_q_y[0]   <= '0;
        r_ovf_x[0] <= REM_W'(i_num_x) >= w_den_top;
        r_ovf_y[0] <= REM_W'(i_num_y) >= w_den_top;
        r_side[0]  <= i_side;
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int SH = QUO_W - 1 - k;
        logic [REM_W-1:0] w_sub;
        logic             w_ge_x;
        logic             w_ge_y;
        logic [QUO_W-1:0] n_q_x;
        logic [QUO_W-1:0] n_q_y;

        assign w_sub  = REM_W'(r_den[k]) << SH;
        assign w_ge_x = r_rem_x[k] >= w_sub;
        assign w_ge_y = r_rem_y[k] >= w_sub;

        always_comb begin
            n_q_x     = r_q_x[k];
            n_q_y     = r_q_y[k];
            n_q_x[SH] = w_ge_x;
            n_q_y[SH] = w_ge_y;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= r_valid[k];
            end
            r_q_x[k+1]   <= n_q_x;
            r_q_y[k+1]   <= n_q_y;
            r_ovf_x[k+1] <= r_ovf_x[k];
            r_ovf_y[k+1] <= r_ovf_y[k];
            r_side[k+1]  <= r_side[k];
        end

        if (k < QUO_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem_x[k+1] <= w_ge_x ? r_rem_x[k] - w_sub : r_rem_x[k];
                r_rem_y[k+1] <= w_ge_y ? r_rem_y[k] - w_sub : r_rem_y[k];
                r_den[k+1]   <= r_den[k];
            end
        end
    end

    assign o_valid = r_valid[QUO_W];
    assign o_quo_x = r_q_x[QUO_W];
    assign o_quo_y = r_q_y[QUO_W];
    assign o_ovf_x = r_ovf_x[QUO_W];
    assign o_ovf_y = r_ovf_y[QUO_W];
    assign o_side  = r_side[QUO_W];

endmodule

`default_nettype wire

### rtl/core/segment_segment_intersection.sv
// Throughput: one word per cycle; o_busy is always low.
// The divider produces one quotient bit per stage.
// The receiver cannot stall; each result shows for one cycle.
// Synchronous active-low reset clears all valid bits; no results until refilled.
// ----------------------------------------------------------------------------
// segment_segment_intersection
// 2D segment intersection by Cramer's rule in signed fixed point, pipelined.
// ----------------------------------------------------------------------------
`default_nettype none
`include "segment_segment_intersection_assert.svh"

module segment_segment_intersection
    import ssi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_c_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_c_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_d_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_d_y,
    output logic                               o_valid,
    output logic signed [COORD_WIDTH-1:0]      o_cross_x,
    output logic signed [COORD_WIDTH-1:0]      o_cross_y,
    output logic                               o_inside_res,
    output logic                               o_parallel,
    output logic                               o_clipped
);

    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 1;
    localparam int PW    = 2 * DW;
    localparam int DTW   = PW + 1;
    localparam int MW    = DTW + W;
    localparam int NW    = MW + 2;
    localparam int DNW   = DTW + 1;
    localparam int QW    = ssi_quo_w(W);
    localparam int SW    = 2 * W + 4;
    localparam int RW    = W + 4;

    localparam logic [QW-1:0]        LIM  = QW'(1) << (W + 1);
    localparam logic signed [RW-1:0] MAXV = RW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);

    assign o_busy = 1'b0;

    // stage 1: differences
    logic                 r1_valid;
    logic signed [DW-1:0] r1_abx, r1_aby, r1_cdx, r1_cdy, r1_acx, r1_acy;
    logic signed [W-1:0]  r1_ax, r1_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_start;
        end
        r1_abx <= DW'(i_b_x) - DW'(i_a_x);
        r1_aby <= DW'(i_b_y) - DW'(i_a_y);
        r1_cdx <= DW'(i_d_x) - DW'(i_c_x);
        r1_cdy <= DW'(i_d_y) - DW'(i_c_y);
        r1_acx <= DW'(i_c_x) - DW'(i_a_x);
        r1_acy <= DW'(i_c_y) - DW'(i_a_y);
        r1_ax  <= i_a_x;
        r1_ay  <= i_a_y;
    end

    // stage 2: cross products
    logic                 r2_valid;
    logic signed [PW-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    logic signed [DW-1:0] r2_abx, r2_aby;
    logic signed [W-1:0]  r2_ax, r2_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_p0  <= r1_cdx * r1_aby;
        r2_p1  <= r1_abx * r1_cdy;
        r2_p2  <= r1_acy * r1_cdx;
        r2_p3  <= r1_acx * r1_cdy;
        r2_p4  <= r1_acy * r1_abx;
        r2_p5  <= r1_acx * r1_aby;
        r2_abx <= r1_abx;
        r2_aby <= r1_aby;
        r2_ax  <= r1_ax;
        r2_ay  <= r1_ay;
    end

    // stage 3: determinants
    logic                  r3_valid;
    logic signed [DTW-1:0] r3_det, r3_det1, r3_det2;
    logic signed [DW-1:0]  r3_abx, r3_aby;
    logic signed [W-1:0]   r3_ax, r3_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_det  <= DTW'(r2_p0) - DTW'(r2_p1);
        r3_det1 <= DTW'(r2_p2) - DTW'(r2_p3);
        r3_det2 <= DTW'(r2_p4) - DTW'(r2_p5);
        r3_abx  <= r2_abx;
        r3_aby  <= r2_aby;
        r3_ax   <= r2_ax;
        r3_ay   <= r2_ay;
    end

    // stage 4: magnitudes and signs
    logic                 r4_valid;
    logic [DTW-1:0]       r4_m, r4_m1, r4_m2;
    logic [W-1:0]         r4_mabx, r4_maby;
    logic                 r4_s, r4_s1, r4_s2, r4_z, r4_z1, r4_z2;
    logic                 r4_neg_x, r4_neg_y;
    logic signed [W-1:0]  r4_ax, r4_ay;
    logic signed [DW-1:0] w4_nabx, w4_naby;

    assign w4_nabx = -r3_abx;
    assign w4_naby = -r3_aby;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_m     <= r3_det[DTW-1]  ? DTW'(-r3_det)  : DTW'(r3_det);
        r4_m1    <= r3_det1[DTW-1] ? DTW'(-r3_det1) : DTW'(r3_det1);
        r4_m2    <= r3_det2[DTW-1] ? DTW'(-r3_det2) : DTW'(r3_det2);
        r4_mabx  <= r3_abx[DW-1] ? w4_nabx[W-1:0] : r3_abx[W-1:0];
        r4_maby  <= r3_aby[DW-1] ? w4_naby[W-1:0] : r3_aby[W-1:0];
        r4_s     <= r3_det[DTW-1];
        r4_s1    <= r3_det1[DTW-1];
        r4_s2    <= r3_det2[DTW-1];
        r4_z     <= r3_det == '0;
        r4_z1    <= r3_det1 == '0;
        r4_z2    <= r3_det2 == '0;
        r4_neg_x <= r3_det1[DTW-1] ^ r3_abx[DW-1] ^ r3_det[DTW-1];
        r4_neg_y <= r3_det1[DTW-1] ^ r3_aby[DW-1] ^ r3_det[DTW-1];
        r4_ax    <= r3_ax;
        r4_ay    <= r3_ay;
    end

    // stage 5: numerator products, inside test
    logic                r5_valid;
    logic [MW-1:0]       r5_num_x, r5_num_y;
    logic [DTW-1:0]      r5_den;
    logic                r5_in, r5_par, r5_neg_x, r5_neg_y;
    logic signed [W-1:0] r5_ax, r5_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_num_x <= MW'(r4_m1) * MW'(r4_mabx);
        r5_num_y <= MW'(r4_m1) * MW'(r4_maby);
        r5_den   <= r4_m;
        r5_in    <= (r4_z1 || (r4_s1 == r4_s && r4_m1 <= r4_m)) &&
                    (r4_z2 || (r4_s2 == r4_s && r4_m2 <= r4_m));
        r5_par   <= r4_z;
        r5_neg_x <= r4_neg_x;
        r5_neg_y <= r4_neg_y;
        r5_ax    <= r4_ax;
        r5_ay    <= r4_ay;
    end

    // stage 6: rounding offset, doubled denominator
    logic           r6_valid;
    logic [NW-1:0]  r6_n_x, r6_n_y;
    logic [DNW-1:0] r6_d;
    logic [SW-1:0]  r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
        r6_n_x  <= (NW'(r5_num_x) << 1) + NW'(r5_den);
        r6_n_y  <= (NW'(r5_num_y) << 1) + NW'(r5_den);
        r6_d    <= DNW'(r5_den) << 1;
        r6_side <= {r5_ax, r5_ay, r5_neg_x, r5_neg_y, r5_in, r5_par};
    end

    logic          w_dv_valid;
    logic [QW-1:0] w_q_x, w_q_y;
    logic          w_ovf_x, w_ovf_y;
    logic [SW-1:0] w_side;

    ssi_divider #(
        .NUM_W  (NW),
        .DEN_W  (DNW),
        .QUO_W  (QW),
        .SIDE_W (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r6_valid),
        .i_num_x (r6_n_x),
        .i_num_y (r6_n_y),
        .i_den   (r6_d),
        .i_side  (r6_side),
        .o_valid (w_dv_valid),
        .o_quo_x (w_q_x),
        .o_quo_y (w_q_y),
        .o_ovf_x (w_ovf_x),
        .o_ovf_y (w_ovf_y),
        .o_side  (w_side)
    );

    // final stage: clamp, sign, offset by A, saturate; all zero for a parallel pair
    logic signed [W-1:0]  w_ax, w_ay;
    logic                 w_neg_x, w_neg_y, w_in, w_par;
    logic [QW-1:0]        w_qc_x, w_qc_y;
    logic signed [RW-1:0] w_qs_x, w_qs_y, w_sum_x, w_sum_y;
    logic                 w_hi_x, w_lo_x, w_hi_y, w_lo_y;
    logic signed [W-1:0]  n_cross_x, n_cross_y;
    logic                 n_inside, n_clipped;

    assign {w_ax, w_ay, w_neg_x, w_neg_y, w_in, w_par} = w_side;

    always_comb begin
        w_qc_x  = (w_ovf_x || w_q_x > LIM) ? LIM : w_q_x;
        w_qc_y  = (w_ovf_y || w_q_y > LIM) ? LIM : w_q_y;
        w_qs_x  = w_neg_x ? -$signed(RW'(w_qc_x)) : $signed(RW'(w_qc_x));
        w_qs_y  = w_neg_y ? -$signed(RW'(w_qc_y)) : $signed(RW'(w_qc_y));
        w_sum_x = RW'(w_ax) + w_qs_x;
        w_sum_y = RW'(w_ay) + w_qs_y;
        w_hi_x  = w_sum_x > MAXV;
        w_lo_x  = w_sum_x < MINV;
        w_hi_y  = w_sum_y > MAXV;
        w_lo_y  = w_sum_y < MINV;
        if (w_par) begin
            n_cross_x = '0;
            n_cross_y = '0;
            n_inside  = 1'b0;
            n_clipped = 1'b0;
        end else begin
            n_cross_x = w_hi_x ? W'(MAXV) : (w_lo_x ? W'(MINV) : W'(w_sum_x));
            n_cross_y = w_hi_y ? W'(MAXV) : (w_lo_y ? W'(MINV) : W'(w_sum_y));
            n_inside  = w_in;
            n_clipped = w_hi_x || w_lo_x || w_hi_y || w_lo_y;
        end
    end

    logic                r_valid;
    logic signed [W-1:0] r_cross_x, r_cross_y;
    logic                r_inside, r_parallel, r_clipped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_dv_valid;
        end
        r_cross_x  <= n_cross_x;
        r_cross_y  <= n_cross_y;
        r_inside   <= n_inside;
        r_parallel <= w_par;
        r_clipped  <= n_clipped;
    end

    assign o_valid      = r_valid;
    assign o_cross_x    = r_cross_x;
    assign o_cross_y    = r_cross_y;
    assign o_inside_res = r_inside;
    assign o_parallel   = r_parallel;
    assign o_clipped    = r_clipped;

    `SSI_ASSERT_IMPL(a_par_zero, o_valid && o_parallel,
        o_cross_x == '0 && o_cross_y == '0 && !o_inside_res, "parallel word not zeroed")
    `SSI_ASSERT_NEVER(a_par_clip, o_valid && o_parallel && o_clipped,
        "parallel word marked clipped")
    `SSI_ASSERT_IMPL(a_in_noclip, o_valid && o_inside_res, !o_clipped,
        "point within both segments was saturated")
    `SSI_ASSERT_IMPL(a_clip_edge, o_valid && o_clipped,
        o_cross_x == W'(MAXV) || o_cross_x == W'(MINV) ||
        o_cross_y == W'(MAXV) || o_cross_y == W'(MINV), "clipped word not at a range end")

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Segment intersection testbench
// Drives segment pairs into the pipelined intersection block and checks every
// result word against an exact predictor built from wide signed arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

class cross_scoreboard;
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               in_seg;
        logic               par;
        logic               clip;
    } t_hit;

    t_hit pending_hits[$];
    int   fails;

    function logic signed [15:0] meet_coord(input logic signed [17:0] base,
            input logic signed [127:0] d1, input logic signed [17:0] dir,
            input logic signed [127:0] dt, inout logic clip);
        logic signed [127:0] num, den, q, r;
        logic neg;
        neg = ((d1 < 0) != (dir < 0)) != (dt < 0);
        num = (d1 < 0 ? -d1 : d1) * (dir < 0 ? -dir : dir);
        den = dt < 0 ? -dt : dt;
        q = (2 * num + den) / (2 * den);
        if (q > 128'sd131072) q = 128'sd131072;
        r = base + (neg ? -q : q);
        if (r > 128'sd32767) begin
            clip = 1'b1;
            return 16'sh7fff;
        end
        if (r < -128'sd32768) begin
            clip = 1'b1;
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    function logic in_span(input logic signed [127:0] n, input logic signed [127:0] dt);
        if (n == 0) return 1'b1;
        if ((n < 0) != (dt < 0)) return 1'b0;
        return (n < 0 ? -n : n) <= (dt < 0 ? -dt : dt);
    endfunction

    function void note_pair(input logic signed [15:0] ax, ay, bx, by, cx, cy, dx, dy);
        logic signed [127:0] abx, aby, cdx, cdy, acx, acy, dt, d1, d2;
        t_hit h;
        abx = bx - ax; aby = by - ay; cdx = dx - cx; cdy = dy - cy;
        acx = cx - ax; acy = cy - ay;
        dt = cdx * aby - abx * cdy;
        h = '0;
        if (dt == 0) begin
            h.par = 1'b1;
        end else begin
            d1 = acy * cdx - acx * cdy;
            d2 = acy * abx - acx * aby;
            h.x = meet_coord(ax, d1, abx[17:0], dt, h.clip);
            h.y = meet_coord(ay, d1, aby[17:0], dt, h.clip);
            h.in_seg = in_span(d1, dt) && in_span(d2, dt);
        end
        pending_hits.push_back(h);
    endfunction

    task report(input string what);
        $display("mismatch: %s", what);
        fails++;
    endtask

    task check_word(input logic [15:0] x, y, input logic ins, par, clp);
        t_hit h;
        if (pending_hits.size() == 0) begin
            report("result with nothing pending");
            return;
        end
        h = pending_hits.pop_front();
        if (x !== h.x) report($sformatf("cross_x %h want %h", x, h.x));
        if (y !== h.y) report($sformatf("cross_y %h want %h", y, h.y));
        if (ins !== h.in_seg) report($sformatf("inside %b want %b", ins, h.in_seg));
        if (par !== h.par) report($sformatf("parallel %b want %b", par, h.par));
        if (clp !== h.clip) report($sformatf("clipped %b want %b", clp, h.clip));
    endtask
endclass

module testbench;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic signed [15:0] i_a_x = '0, i_a_y = '0, i_b_x = '0, i_b_y = '0;
    logic signed [15:0] i_c_x = '0, i_c_y = '0, i_d_x = '0, i_d_y = '0;
    logic o_busy, o_valid, o_inside_res, o_parallel, o_clipped;
    logic signed [15:0] o_cross_x, o_cross_y;
    cross_scoreboard sb = new();

    segment_segment_intersection u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_word(o_cross_x, o_cross_y, o_inside_res, o_parallel, o_clipped);
        if (i_rst_n && i_start && !o_busy)
            sb.note_pair(i_a_x, i_a_y, i_b_x, i_b_y, i_c_x, i_c_y, i_d_x, i_d_y);
    end

    task automatic send_pair(input logic [15:0] ax, ay, bx, by, cx, cy, dx, dy,
            input bit gaps);
        int n;
        if (gaps && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 5);
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_start <= 1'b1;
        {i_a_x, i_a_y, i_b_x, i_b_y} <= {ax, ay, bx, by};
        {i_c_x, i_c_y, i_d_x, i_d_y} <= {cx, cy, dx, dy};
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 2047) - 1024);
            2: return $urandom_range(0, 1) ? 16'(16'h7fff - $urandom_range(0, 7))
                                           : 16'(16'h8000 + $urandom_range(0, 7));
            default: return 16'($urandom_range(0, 255) - 128);
        endcase
    endfunction

    initial begin
        logic [15:0] p[8];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_pair(0, 0, 256, 256, 0, 256, 256, 0, 1'b0);
        send_pair(0, 0, 256, 0, 0, 256, 256, 256, 1'b0);
        send_pair(0, 0, 256, 256, 512, 512, 768, 768, 1'b0);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_pair(0, 0, 256, 0, 256, 0, 256, 256, 1'b0);
        send_pair(0, 0, 256, 0, 0, 0, 0, 256, 1'b0);
        send_pair(0, 0, 256, 0, 512, -256, 512, 256, 1'b0);
        send_pair(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff,
                  16'h7fff, 16'h8000, 1'b0);
        send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8001, 16'h7fff, 16'h7fff,
                  16'h7ffe, 16'h7fff, 1'b0);
        send_pair(0, 0, 1, 0, 0, 1, 1, 2, 1'b0);
        send_pair(0, 0, 1, 1, 0, 1, 1, 0, 1'b0);
        send_pair(0, 0, 3, 0, 1, 0, 2, 3, 1'b0);
        send_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  16'hffff, 16'hffff, 1'b0);
        send_pair(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h5555, 16'h5555,
                  16'haaaa, 16'haaaa, 1'b0);
        for (int k = 0; k < 1200; k++) begin
            foreach (p[j]) p[j] = pick_coord();
            if ($urandom_range(0, 9) == 0) begin
                p[6] = p[4] + (p[2] - p[0]);
                p[7] = p[5] + (p[3] - p[1]);
            end
            send_pair(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], k < 1000);
        end
        i_start <= 1'b0;
        while (sb.pending_hits.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #200000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire
